// ===== hdl/hfs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfs_pkg
// Shared types, codes and helpers of the heartbeat fail-safe scheduler.
// ----------------------------------------------------------------------------
package hfs_pkg;

  localparam int EPOCH_WIDTH = 40;
  localparam int US_W        = 64;
  localparam int SECS_W      = 32;
  localparam int MULT_W      = 20;
  localparam int THR_W       = SECS_W + MULT_W;
  localparam int ADDR_W      = 6;
  localparam int DATA_W      = 64;

  localparam logic [MULT_W-1:0] USEC_PER_SEC = MULT_W'(1000000);

  typedef enum logic [2:0] {
    ST_NA        = 3'd0,
    ST_GUARD     = 3'd1,
    ST_PFAIL     = 3'd2,
    ST_UNTRUSTED = 3'd3,
    ST_WAIT      = 3'd4,
    ST_DUE       = 3'd5,
    ST_COMMITTED = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    CMD_EVAL = 3'd0,
    CMD_ARM  = 3'd1,
    CMD_DONE = 3'd2,
    CMD_FAIL = 3'd3,
    CMD_ACK  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    REG_MAX_FAILURES = 3'd0,
    REG_MAX_AGE      = 3'd1,
    REG_PERIOD       = 3'd2,
    REG_MIN_ADVANCE  = 3'd3,
    REG_EPOCH_LOW    = 3'd4,
    REG_EPOCH_HIGH   = 3'd5
  } reg_idx_t;

  localparam logic [7:0]             RST_MAX_FAILURES = 8'd3;
  localparam logic [SECS_W-1:0]      RST_MAX_AGE_S    = SECS_W'(300);
  localparam logic [SECS_W-1:0]      RST_PERIOD_S     = SECS_W'(60);
  localparam logic [SECS_W-1:0]      RST_MIN_ADVANCE  = SECS_W'(30);
  localparam logic [EPOCH_WIDTH-1:0] RST_EPOCH_LOW    = EPOCH_WIDTH'(64'd1704067200);
  localparam logic [EPOCH_WIDTH-1:0] RST_EPOCH_HIGH   = EPOCH_WIDTH'(64'd4102444800);
  localparam logic [THR_W-1:0]       RST_MAX_AGE_US   = THR_W'(64'd300000000);
  localparam logic [THR_W-1:0]       RST_PERIOD_US    = THR_W'(64'd60000000);

  typedef struct packed {
    logic [7:0]             max_failures;
    logic [THR_W-1:0]       max_age_us;
    logic [THR_W-1:0]       period_us;
    logic [SECS_W-1:0]      min_advance_s;
    logic [EPOCH_WIDTH-1:0] epoch_low_s;
    logic [EPOCH_WIDTH-1:0] epoch_high_s;
  } cfg_t;

  typedef struct packed {
    cmd_t                   command;
    logic [US_W-1:0]        now_us;
    logic [EPOCH_WIDTH-1:0] epoch_in_s;
    logic                   outcome_uncertain;
    logic                   guard_active;
    logic                   session_active;
    logic                   grant_active;
    logic                   time_trusted;
    logic                   floor_valid;
    logic [EPOCH_WIDTH-1:0] floor_epoch_s;
  } req_t;

  typedef struct packed {
    status_t                status;
    logic                   commit_pulse;
    logic [EPOCH_WIDTH-1:0] commit_epoch_s;
    logic                   guard_needed;
    logic                   failsafe_needed;
  } res_t;

  // elapsed time since anchor (zero if clock has not moved on) against threshold
  function automatic logic span_reached(input logic [US_W-1:0] anchor,
                                        input logic [US_W-1:0] now,
                                        input logic [THR_W-1:0] thr);
    logic [US_W-1:0] diff;
    diff = (now > anchor) ? (now - anchor) : '0;
    return diff >= US_W'(thr);
  endfunction

endpackage

// ===== hdl/hfs_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfs_cfg
// APB register file; second thresholds are scaled to microseconds on write.
// ----------------------------------------------------------------------------
module hfs_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hfs_pkg::ADDR_W-1:0] paddr,
  input  logic [hfs_pkg::DATA_W-1:0] pwdata,
  output logic [hfs_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output hfs_pkg::cfg_t              cfg
);
  import hfs_pkg::*;

  logic [7:0]             max_failures;
  logic [SECS_W-1:0]      max_age_s;
  logic [SECS_W-1:0]      period_s;
  logic [SECS_W-1:0]      min_advance_s;
  logic [EPOCH_WIDTH-1:0] epoch_low_s;
  logic [EPOCH_WIDTH-1:0] epoch_high_s;
  logic [THR_W-1:0]       max_age_us;
  logic [THR_W-1:0]       period_us;
  logic [THR_W-1:0]       scaled;
  logic                   wr;
  reg_idx_t               idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign scaled = THR_W'(pwdata[SECS_W-1:0]) * THR_W'(USEC_PER_SEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_failures  <= RST_MAX_FAILURES;
      max_age_s     <= RST_MAX_AGE_S;
      period_s      <= RST_PERIOD_S;
      min_advance_s <= RST_MIN_ADVANCE;
      epoch_low_s   <= RST_EPOCH_LOW;
      epoch_high_s  <= RST_EPOCH_HIGH;
      max_age_us    <= RST_MAX_AGE_US;
      period_us     <= RST_PERIOD_US;
    end else if (wr) begin
      unique case (idx)
        REG_MAX_FAILURES: max_failures <= pwdata[7:0];
        REG_MAX_AGE: begin
          max_age_s  <= pwdata[SECS_W-1:0];
          max_age_us <= scaled;
        end
        REG_PERIOD: begin
          period_s  <= pwdata[SECS_W-1:0];
          period_us <= scaled;
        end
        REG_MIN_ADVANCE: min_advance_s <= pwdata[SECS_W-1:0];
        REG_EPOCH_LOW:   epoch_low_s   <= pwdata[EPOCH_WIDTH-1:0];
        REG_EPOCH_HIGH:  epoch_high_s  <= pwdata[EPOCH_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MAX_FAILURES: prdata = DATA_W'(max_failures);
      REG_MAX_AGE:      prdata = DATA_W'(max_age_s);
      REG_PERIOD:       prdata = DATA_W'(period_s);
      REG_MIN_ADVANCE:  prdata = DATA_W'(min_advance_s);
      REG_EPOCH_LOW:    prdata = DATA_W'(epoch_low_s);
      REG_EPOCH_HIGH:   prdata = DATA_W'(epoch_high_s);
      default:          prdata = '0;
    endcase
  end

  assign cfg.max_failures  = max_failures;
  assign cfg.max_age_us    = max_age_us;
  assign cfg.period_us     = period_us;
  assign cfg.min_advance_s = min_advance_s;
  assign cfg.epoch_low_s   = epoch_low_s;
  assign cfg.epoch_high_s  = epoch_high_s;

endmodule

// ===== hdl/hfs_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfs_engine
// Watchdog state and the combinational decision for one request.
// ----------------------------------------------------------------------------
module hfs_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  hfs_pkg::req_t req,
  input  hfs_pkg::cfg_t cfg,
  output hfs_pkg::res_t res
);
  import hfs_pkg::*;

  logic                   armed, armed_next;
  logic [US_W-1:0]        retry_anchor_us, retry_anchor_us_next;
  logic [US_W-1:0]        durable_anchor_us, durable_anchor_us_next;
  logic                   have_epoch, have_epoch_next;
  logic [EPOCH_WIDTH-1:0] last_epoch_s, last_epoch_s_next;
  logic [7:0]             fail_count, fail_count_next;
  logic                   failsafe_latched, failsafe_latched_next;
  status_t                last_status, last_status_next;

  logic                   age_due, period_due, moved_on, sane;
  logic [EPOCH_WIDTH-1:0] base;
  logic [EPOCH_WIDTH-1:0] advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      armed             <= 1'b0;
      retry_anchor_us   <= '0;
      durable_anchor_us <= '0;
      have_epoch        <= 1'b0;
      last_epoch_s      <= '0;
      fail_count        <= '0;
      failsafe_latched  <= 1'b0;
      last_status       <= ST_NA;
    end else if (fire) begin
      armed             <= armed_next;
      retry_anchor_us   <= retry_anchor_us_next;
      durable_anchor_us <= durable_anchor_us_next;
      have_epoch        <= have_epoch_next;
      last_epoch_s      <= last_epoch_s_next;
      fail_count        <= fail_count_next;
      failsafe_latched  <= failsafe_latched_next;
      last_status       <= last_status_next;
    end
  end

  // epoch floor: larger of committed and persisted
  always_comb begin
    base     = '0;
    moved_on = 1'b1;
    if (have_epoch) begin
      base = (req.floor_valid && req.floor_epoch_s > last_epoch_s) ?
             req.floor_epoch_s : last_epoch_s;
    end else if (req.floor_valid) begin
      base = req.floor_epoch_s;
    end
    advance = req.epoch_in_s - base;
    if (have_epoch || req.floor_valid) begin
      moved_on = (req.epoch_in_s > base) &&
                 (advance >= EPOCH_WIDTH'(cfg.min_advance_s));
    end
  end

  assign age_due    = span_reached(durable_anchor_us, req.now_us, cfg.max_age_us);
  assign period_due = span_reached(retry_anchor_us, req.now_us, cfg.period_us);
  assign sane       = req.time_trusted && (req.epoch_in_s >= cfg.epoch_low_s) &&
                      (req.epoch_in_s <= cfg.epoch_high_s);

  always_comb begin
    armed_next             = armed;
    retry_anchor_us_next   = retry_anchor_us;
    durable_anchor_us_next = durable_anchor_us;
    have_epoch_next        = have_epoch;
    last_epoch_s_next      = last_epoch_s;
    fail_count_next        = fail_count;
    failsafe_latched_next  = failsafe_latched;
    last_status_next       = last_status;
    res                    = '0;
    res.status             = ST_NA;

    unique case (req.command)
      CMD_EVAL: begin
        if (req.guard_active) begin
          res.status       = ST_GUARD;
          res.guard_needed = 1'b1;
        end else if (!req.session_active || !req.grant_active) begin
          res.status = ST_NA;
        end else if (armed && (fail_count >= cfg.max_failures || age_due)) begin
          res.status          = ST_PFAIL;
          res.failsafe_needed = !failsafe_latched;
        end else if (!sane) begin
          res.status = ST_UNTRUSTED;
        end else if (!armed || !period_due || !moved_on) begin
          res.status = ST_WAIT;
        end else begin
          res.status         = ST_DUE;
          res.commit_pulse   = 1'b1;
          res.commit_epoch_s = req.epoch_in_s;
        end
      end
      CMD_ARM: begin
        armed_next             = 1'b1;
        retry_anchor_us_next   = req.now_us;
        durable_anchor_us_next = req.now_us;
      end
      CMD_DONE: begin
        armed_next             = 1'b1;
        retry_anchor_us_next   = req.now_us;
        durable_anchor_us_next = req.now_us;
        if (!have_epoch || req.epoch_in_s > last_epoch_s) begin
          have_epoch_next   = 1'b1;
          last_epoch_s_next = req.epoch_in_s;
        end
        fail_count_next       = '0;
        failsafe_latched_next = 1'b0;
        last_status_next      = ST_COMMITTED;
      end
      CMD_FAIL: begin
        armed_next           = 1'b1;
        retry_anchor_us_next = req.now_us;
        if (req.outcome_uncertain) begin
          last_status_next = ST_GUARD;
        end else begin
          if (fail_count != 8'hFF) fail_count_next = fail_count + 8'd1;
          last_status_next = ST_PFAIL;
        end
      end
      CMD_ACK: begin
        failsafe_latched_next = 1'b1;
        last_status_next      = ST_PFAIL;
      end
      default: ;
    endcase

    if (req.command != CMD_EVAL) res.status = last_status_next;
  end

endmodule

// ===== hdl/heartbeat_failsafe_scheduler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heartbeat_failsafe_scheduler_core
// Liveness heartbeat watchdog with fail-safe policy, one result per request.
// ----------------------------------------------------------------------------
// Takes one request per clock while req_stall is low and returns exactly one
// result per request: the request is captured in an input register, decided
// and applied to the watchdog state as it moves to the output register, and
// the result is held in the output register until taken. The sustained rate
// of one request per cycle, while results are not stalled, is set by the
// state update in the decision stage, so each request sees the state left
// by the one before it. Second thresholds are scaled to microseconds when
// the register is written. There is no clearing pass after reset.
module heartbeat_failsafe_scheduler_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hfs_pkg::ADDR_W-1:0]      paddr,
  input  logic [hfs_pkg::DATA_W-1:0]      pwdata,
  output logic [hfs_pkg::DATA_W-1:0]      prdata,
  output logic                            pready,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic [2:0]                      command,
  input  logic [63:0]                     now_us,
  input  logic [hfs_pkg::EPOCH_WIDTH-1:0] epoch_in_s,
  input  logic                            outcome_uncertain,
  input  logic                            guard_active,
  input  logic                            session_active,
  input  logic                            grant_active,
  input  logic                            time_trusted,
  input  logic                            floor_valid,
  input  logic [hfs_pkg::EPOCH_WIDTH-1:0] floor_epoch_s,
  output logic                            res_valid,
  input  logic                            res_stall,
  output logic [2:0]                      status,
  output logic                            commit_pulse,
  output logic [hfs_pkg::EPOCH_WIDTH-1:0] commit_epoch_s,
  output logic                            guard_needed,
  output logic                            failsafe_needed
);
  import hfs_pkg::*;

  cfg_t cfg;
  req_t stage, req_in;
  logic stage_valid, stage_valid_next;
  res_t res_comb, res;
  logic res_valid_next;
  logic advance, req_accept;

  hfs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hfs_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .fire (stage_valid && advance),
    .req  (stage),
    .cfg  (cfg),
    .res  (res_comb)
  );

  assign req_in.command           = cmd_t'(command);
  assign req_in.now_us            = now_us;
  assign req_in.epoch_in_s        = epoch_in_s;
  assign req_in.outcome_uncertain = outcome_uncertain;
  assign req_in.guard_active      = guard_active;
  assign req_in.session_active    = session_active;
  assign req_in.grant_active      = grant_active;
  assign req_in.time_trusted      = time_trusted;
  assign req_in.floor_valid       = floor_valid;
  assign req_in.floor_epoch_s     = floor_epoch_s;

  assign advance    = !res_valid || !res_stall;
  assign req_stall  = stage_valid && !advance;
  assign req_accept = req_valid && !req_stall;

  always_comb begin
    stage_valid_next = stage_valid;
    if (req_accept)   stage_valid_next = 1'b1;
    else if (advance) stage_valid_next = 1'b0;
    res_valid_next = res_valid;
    if (advance) res_valid_next = stage_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      stage_valid <= stage_valid_next;
      res_valid   <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) stage <= req_in;
    if (advance && stage_valid) res <= res_comb;
  end

  assign status          = res.status;
  assign commit_pulse    = res.commit_pulse;
  assign commit_epoch_s  = res.commit_epoch_s;
  assign guard_needed    = res.guard_needed;
  assign failsafe_needed = res.failsafe_needed;

  a_commit_due: assert property (@(posedge clk) disable iff (rst)
    res_valid && commit_pulse |-> res.status == ST_DUE)
    else $error("commit without due status");

  a_failsafe_pfail: assert property (@(posedge clk) disable iff (rst)
    res_valid && failsafe_needed |-> res.status == ST_PFAIL)
    else $error("fail-safe outside persist-failed status");

  a_epoch_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !commit_pulse |-> commit_epoch_s == '0)
    else $error("commit epoch without commit");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    !stage_valid |-> !req_stall)
    else $error("request stalled with empty input stage");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !res_valid |=> res_valid)
    else $error("request lost between stages");

endmodule

// ===== bench/heartbeat_failsafe_scheduler_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heartbeat_failsafe_scheduler_core_tb
// Self-checking regression of the heartbeat fail-safe scheduler.
// ----------------------------------------------------------------------------
// A directed table walks the evaluate priority chain, the commit and failure
// reports, the acknowledge path, unused commands and the field extremes.
// Random phases follow under several register settings: defaults, small
// thresholds, both threshold extremes, zero thresholds, an inverted epoch
// band and random values. Each request is predicted by a behavioral copy of
// the watchdog. Results are compared field by field in order. Both channels
// idle and stall at random, except in one phase that runs with neither.
// ----------------------------------------------------------------------------
module heartbeat_failsafe_scheduler_core_tb;
  import hfs_pkg::*;

  localparam logic [2:0] CMD_RSVD = 3'd7;
  localparam logic [63:0] SEC_USEC = 64'd1000000;
  localparam logic [EPOCH_WIDTH-1:0] EPOCH_MAX = '1;
  localparam logic [63:0] NOW_MAX = '1;

  // request flags, packed as {uncertain, guard, target, grant, trusted, fvalid}
  localparam logic [5:0] F_UNC    = 6'b100000;
  localparam logic [5:0] F_GUARD  = 6'b010000;
  localparam logic [5:0] F_TARGET = 6'b001000;
  localparam logic [5:0] F_GRANT  = 6'b000100;
  localparam logic [5:0] F_TRUST  = 6'b000010;
  localparam logic [5:0] F_FLOOR  = 6'b000001;
  localparam logic [5:0] F_LIVE   = F_TARGET | F_GRANT | F_TRUST;

  typedef struct packed {
    logic [2:0]             cmd;
    logic [63:0]            now_us;
    logic [EPOCH_WIDTH-1:0] epoch_s;
    logic                   uncertain;
    logic                   guard;
    logic                   target;
    logic                   grant;
    logic                   trusted;
    logic                   fvalid;
    logic [EPOCH_WIDTH-1:0] floor_s;
  } hb_req;

  typedef struct {
    hb_req req;
    bit    typed;
    res_t  want;
  } stim_row;

  logic                   clk;
  logic                   rst;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [ADDR_W-1:0]      paddr;
  logic [DATA_W-1:0]      pwdata;
  logic [DATA_W-1:0]      prdata;
  logic                   pready;
  logic                   req_valid;
  logic                   req_stall;
  logic [2:0]             command;
  logic [63:0]            now_us;
  logic [EPOCH_WIDTH-1:0] epoch_in_s;
  logic                   outcome_uncertain;
  logic                   guard_active;
  logic                   session_active;
  logic                   grant_active;
  logic                   time_trusted;
  logic                   floor_valid;
  logic [EPOCH_WIDTH-1:0] floor_epoch_s;
  logic                   res_valid;
  logic                   res_stall;
  logic [2:0]             status;
  logic                   commit_pulse;
  logic [EPOCH_WIDTH-1:0] commit_epoch_s;
  logic                   guard_needed;
  logic                   failsafe_needed;

  heartbeat_failsafe_scheduler_core uut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .command(command),
    .now_us(now_us),
    .epoch_in_s(epoch_in_s),
    .outcome_uncertain(outcome_uncertain),
    .guard_active(guard_active),
    .session_active(session_active),
    .grant_active(grant_active),
    .time_trusted(time_trusted),
    .floor_valid(floor_valid),
    .floor_epoch_s(floor_epoch_s),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .status(status),
    .commit_pulse(commit_pulse),
    .commit_epoch_s(commit_epoch_s),
    .guard_needed(guard_needed),
    .failsafe_needed(failsafe_needed)
  );

  // register shadow
  logic [7:0]             lim_failures;
  logic [SECS_W-1:0]      lim_age_s;
  logic [SECS_W-1:0]      lim_period_s;
  logic [SECS_W-1:0]      lim_advance_s;
  logic [EPOCH_WIDTH-1:0] band_low_s;
  logic [EPOCH_WIDTH-1:0] band_high_s;

  // watchdog state copy
  logic                   armed;
  logic [63:0]            retry_anchor_us;
  logic [63:0]            durable_anchor_us;
  logic                   have_epoch;
  logic [EPOCH_WIDTH-1:0] last_epoch_s;
  logic [7:0]             fail_count;
  logic                   failsafe_latched;
  status_t                last_status;

  res_t    expected_results[$];
  stim_row directed_rows[$];
  int      mismatch_count = 0;
  bit      calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("heartbeat_failsafe_scheduler_core regression: fail");
    $finish;
  end

  function automatic logic span_met(input logic [63:0] anchor, input logic [63:0] now,
                                    input logic [SECS_W-1:0] secs);
    logic [63:0] diff;
    diff = (now > anchor) ? now - anchor : 64'd0;
    return diff >= 64'(secs) * SEC_USEC;
  endfunction

  function automatic logic epoch_advanced(input logic [EPOCH_WIDTH-1:0] cand,
                                          input logic fvalid,
                                          input logic [EPOCH_WIDTH-1:0] floor_s);
    logic [EPOCH_WIDTH-1:0] base;
    if (have_epoch) begin
      base = (fvalid && floor_s > last_epoch_s) ? floor_s : last_epoch_s;
    end else if (fvalid) begin
      base = floor_s;
    end else begin
      return 1'b1;
    end
    if (cand <= base) return 1'b0;
    return 64'(cand - base) >= 64'(lim_advance_s);
  endfunction

  function automatic res_t predict_heartbeat(input hb_req r);
    res_t o;
    o = '0;
    o.status = ST_NA;
    if (r.cmd == CMD_EVAL) begin
      if (r.guard) begin
        o.status = ST_GUARD;
        o.guard_needed = 1'b1;
      end else if (!r.target || !r.grant) begin
        o.status = ST_NA;
      end else if (armed && (fail_count >= lim_failures ||
                             span_met(durable_anchor_us, r.now_us, lim_age_s))) begin
        o.status = ST_PFAIL;
        o.failsafe_needed = !failsafe_latched;
      end else if (!r.trusted || r.epoch_s < band_low_s || r.epoch_s > band_high_s) begin
        o.status = ST_UNTRUSTED;
      end else if (!armed || !span_met(retry_anchor_us, r.now_us, lim_period_s) ||
                   !epoch_advanced(r.epoch_s, r.fvalid, r.floor_s)) begin
        o.status = ST_WAIT;
      end else begin
        o.status = ST_DUE;
        o.commit_pulse = 1'b1;
        o.commit_epoch_s = r.epoch_s;
      end
    end else begin
      case (r.cmd)
        CMD_ARM: begin
          armed = 1'b1;
          retry_anchor_us = r.now_us;
          durable_anchor_us = r.now_us;
        end
        CMD_DONE: begin
          armed = 1'b1;
          retry_anchor_us = r.now_us;
          durable_anchor_us = r.now_us;
          if (!have_epoch || r.epoch_s > last_epoch_s) begin
            have_epoch = 1'b1;
            last_epoch_s = r.epoch_s;
          end
          fail_count = 8'd0;
          failsafe_latched = 1'b0;
          last_status = ST_COMMITTED;
        end
        CMD_FAIL: begin
          armed = 1'b1;
          retry_anchor_us = r.now_us;
          if (r.uncertain) begin
            last_status = ST_GUARD;
          end else begin
            if (fail_count != 8'hFF) fail_count++;
            last_status = ST_PFAIL;
          end
        end
        CMD_ACK: begin
          failsafe_latched = 1'b1;
          last_status = ST_PFAIL;
        end
        default: ;
      endcase
      o.status = last_status;
    end
    return o;
  endfunction

  function automatic res_t result_of(input status_t s, input logic go,
                                     input logic [EPOCH_WIDTH-1:0] ep,
                                     input logic gn, input logic fn);
    res_t o;
    o.status = s;
    o.commit_pulse = go;
    o.commit_epoch_s = ep;
    o.guard_needed = gn;
    o.failsafe_needed = fn;
    return o;
  endfunction

  function automatic hb_req make_req(input logic [2:0] cmd, input logic [63:0] now,
                                     input logic [EPOCH_WIDTH-1:0] ep,
                                     input logic [5:0] flags,
                                     input logic [EPOCH_WIDTH-1:0] floor_s);
    hb_req r;
    r.cmd = cmd;
    r.now_us = now;
    r.epoch_s = ep;
    {r.uncertain, r.guard, r.target, r.grant, r.trusted, r.fvalid} = flags;
    r.floor_s = floor_s;
    return r;
  endfunction

  task automatic add_row(input logic [2:0] cmd, input logic [63:0] now,
                         input logic [EPOCH_WIDTH-1:0] ep, input logic [5:0] flags,
                         input logic [EPOCH_WIDTH-1:0] floor_s, input bit typed,
                         input res_t want);
    stim_row row;
    row.req = make_req(cmd, now, ep, flags, floor_s);
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  task automatic send_request(input hb_req r, input bit typed, input res_t want);
    res_t predicted;
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 17) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    command           <= r.cmd;
    now_us            <= r.now_us;
    epoch_in_s        <= r.epoch_s;
    outcome_uncertain <= r.uncertain;
    guard_active      <= r.guard;
    session_active    <= r.target;
    grant_active      <= r.grant;
    time_trusted      <= r.trusted;
    floor_valid       <= r.fvalid;
    floor_epoch_s     <= r.floor_s;
    req_valid         <= 1'b1;
    do @(posedge clk); while (req_stall);
    predicted = predict_heartbeat(r);
    expected_results.push_back(typed ? want : predicted);
  endtask

  task automatic drain_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic reg_write(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(int'(idx) * 8);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_MAX_FAILURES: lim_failures  = value[7:0];
      REG_MAX_AGE:      lim_age_s     = value[SECS_W-1:0];
      REG_PERIOD:       lim_period_s  = value[SECS_W-1:0];
      REG_MIN_ADVANCE:  lim_advance_s = value[SECS_W-1:0];
      REG_EPOCH_LOW:    band_low_s    = value[EPOCH_WIDTH-1:0];
      REG_EPOCH_HIGH:   band_high_s   = value[EPOCH_WIDTH-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_limits(input logic [7:0] fails, input logic [31:0] age,
                                input logic [31:0] period, input logic [31:0] advance,
                                input logic [EPOCH_WIDTH-1:0] lo,
                                input logic [EPOCH_WIDTH-1:0] hi);
    drain_results();
    reg_write(REG_MAX_FAILURES, DATA_W'(fails));
    reg_write(REG_MAX_AGE, DATA_W'(age));
    reg_write(REG_PERIOD, DATA_W'(period));
    reg_write(REG_MIN_ADVANCE, DATA_W'(advance));
    reg_write(REG_EPOCH_LOW, DATA_W'(lo));
    reg_write(REG_EPOCH_HIGH, DATA_W'(hi));
  endtask

  // mostly well-formed traffic on a moving clock and wall epoch, some noise
  task automatic random_phase(input int count, input int unsigned step_s,
                              input logic [EPOCH_WIDTH-1:0] epoch_base);
    hb_req r;
    logic [63:0] clock_us;
    logic [EPOCH_WIDTH-1:0] wall_s;
    int unsigned adv_s;
    int unsigned roll;
    clock_us = 64'($urandom);
    wall_s = epoch_base;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 2) drain_results();
      adv_s = $urandom_range(0, 2 * step_s);
      clock_us += 64'(adv_s) * SEC_USEC + 64'($urandom_range(0, 999999));
      wall_s += EPOCH_WIDTH'(adv_s);
      if ($urandom_range(0, 99) < 3)
        clock_us -= 64'($urandom_range(0, step_s)) * SEC_USEC;
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        r = make_req(3'($urandom), {$urandom, $urandom}, EPOCH_WIDTH'({$urandom, $urandom}),
                     6'($urandom), EPOCH_WIDTH'({$urandom, $urandom}));
      end else begin
        roll = $urandom_range(0, 99);
        r.cmd = (roll < 55) ? CMD_EVAL : (roll < 68) ? CMD_DONE :
                (roll < 82) ? CMD_FAIL : (roll < 88) ? CMD_ARM : CMD_ACK;
        r.now_us = clock_us;
        if ($urandom_range(0, 9) == 0)
          r.epoch_s = wall_s - EPOCH_WIDTH'($urandom_range(0, 4 * step_s));
        else
          r.epoch_s = wall_s + EPOCH_WIDTH'($urandom_range(0, 2));
        r.uncertain = ($urandom_range(0, 3) == 0);
        r.guard     = ($urandom_range(0, 99) < 8);
        r.target    = ($urandom_range(0, 99) < 92);
        r.grant     = ($urandom_range(0, 99) < 92);
        r.trusted   = ($urandom_range(0, 99) < 92);
        r.fvalid    = 1'($urandom);
        if ($urandom_range(0, 9) == 0)
          r.floor_s = wall_s + EPOCH_WIDTH'($urandom_range(0, step_s));
        else
          r.floor_s = wall_s - EPOCH_WIDTH'($urandom_range(0, 4 * step_s));
      end
      send_request(r, 1'b0, '0);
    end
  endtask

  function automatic void compare_field(input string field, input logic [63:0] want,
                                        input logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0h actual %0h", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t ns: unexpected result, status expected none actual %0d",
                 $time, status);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        compare_field("status", 64'(want.status), 64'(status));
        compare_field("commit_pulse", 64'(want.commit_pulse), 64'(commit_pulse));
        compare_field("commit_epoch_s", 64'(want.commit_epoch_s), 64'(commit_epoch_s));
        compare_field("guard_needed", 64'(want.guard_needed), 64'(guard_needed));
        compare_field("failsafe_needed", 64'(want.failsafe_needed), 64'(failsafe_needed));
      end
    end
  end

  always @(negedge clk) begin
    res_stall <= !calm && ($urandom_range(0, 99) < 17);
  end

  initial begin
    hb_req r;
    logic [63:0] t0;
    logic [63:0] per;
    logic [EPOCH_WIDTH-1:0] e0;
    logic [EPOCH_WIDTH-1:0] lo;
    logic [31:0] rnd_period;

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_valid = 1'b0;
    command = CMD_EVAL;
    now_us = '0;
    epoch_in_s = '0;
    outcome_uncertain = 1'b0;
    guard_active = 1'b0;
    session_active = 1'b0;
    grant_active = 1'b0;
    time_trusted = 1'b0;
    floor_valid = 1'b0;
    floor_epoch_s = '0;
    res_stall = 1'b0;

    lim_failures = RST_MAX_FAILURES;
    lim_age_s = RST_MAX_AGE_S;
    lim_period_s = RST_PERIOD_S;
    lim_advance_s = RST_MIN_ADVANCE;
    band_low_s = RST_EPOCH_LOW;
    band_high_s = RST_EPOCH_HIGH;
    armed = 1'b0;
    retry_anchor_us = '0;
    durable_anchor_us = '0;
    have_epoch = 1'b0;
    last_epoch_s = '0;
    fail_count = '0;
    failsafe_latched = 1'b0;
    last_status = ST_NA;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    t0 = 64'd5000000;
    per = 64'd60000000;
    e0 = EPOCH_WIDTH'(64'd2000000000);

    // evaluate priority chain from reset, unarmed
    add_row(CMD_EVAL, 0, e0, F_GUARD, 0, 1, result_of(ST_GUARD, 0, 0, 1, 0));
    add_row(CMD_EVAL, 0, e0, F_GRANT | F_TRUST, 0, 1, result_of(ST_NA, 0, 0, 0, 0));
    add_row(CMD_EVAL, 0, e0, F_TARGET | F_TRUST, 0, 1, result_of(ST_NA, 0, 0, 0, 0));
    add_row(CMD_EVAL, 0, e0, F_TARGET | F_GRANT, 0, 1, result_of(ST_UNTRUSTED, 0, 0, 0, 0));
    add_row(CMD_EVAL, 0, RST_EPOCH_LOW - 1, F_LIVE, 0, 1,
            result_of(ST_UNTRUSTED, 0, 0, 0, 0));
    add_row(CMD_EVAL, 0, EPOCH_MAX, F_LIVE, 0, 1, result_of(ST_UNTRUSTED, 0, 0, 0, 0));
    add_row(CMD_EVAL, 0, e0, F_LIVE, 0, 1, result_of(ST_WAIT, 0, 0, 0, 0));
    add_row(CMD_RSVD, NOW_MAX, EPOCH_MAX, 6'b111111, EPOCH_MAX, 1,
            result_of(ST_NA, 0, 0, 0, 0));
    // armed cadence and epoch floors
    add_row(CMD_ARM, t0, 0, 0, 0, 1, result_of(ST_NA, 0, 0, 0, 0));
    add_row(CMD_EVAL, t0 + per - 1, e0, F_LIVE, 0, 1, result_of(ST_WAIT, 0, 0, 0, 0));
    add_row(CMD_EVAL, t0 + per, e0, F_LIVE, 0, 1, result_of(ST_DUE, 1, e0, 0, 0));
    add_row(CMD_EVAL, t0 + per, e0, F_LIVE | F_FLOOR, e0 - 29, 0, '0);
    add_row(CMD_EVAL, t0 + per, e0, F_LIVE | F_FLOOR, e0 - 30, 0, '0);
    add_row(CMD_EVAL, t0 + per, e0, F_LIVE | F_FLOOR, EPOCH_MAX, 0, '0);
    add_row(CMD_DONE, t0 + per, e0, 0, 0, 1, result_of(ST_COMMITTED, 0, 0, 0, 0));
    add_row(CMD_EVAL, t0 + 2 * per, e0 + 29, F_LIVE, 0, 0, '0);
    add_row(CMD_EVAL, t0 + 2 * per, e0 + 30, F_LIVE | F_FLOOR, e0 - 5, 0, '0);
    // failure reports, fail-safe raised once, acknowledged, cleared by commit
    add_row(CMD_FAIL, t0 + 2 * per, 0, F_UNC, 0, 1, result_of(ST_GUARD, 0, 0, 0, 0));
    add_row(CMD_FAIL, t0 + 2 * per, 0, 0, 0, 1, result_of(ST_PFAIL, 0, 0, 0, 0));
    add_row(CMD_FAIL, t0 + 2 * per, 0, 0, 0, 1, result_of(ST_PFAIL, 0, 0, 0, 0));
    add_row(CMD_FAIL, t0 + 2 * per, 0, 0, 0, 1, result_of(ST_PFAIL, 0, 0, 0, 0));
    add_row(CMD_EVAL, t0 + 2 * per, e0 + 60, F_LIVE, 0, 1, result_of(ST_PFAIL, 0, 0, 0, 1));
    add_row(CMD_ACK, t0 + 2 * per, 0, 0, 0, 1, result_of(ST_PFAIL, 0, 0, 0, 0));
    add_row(CMD_EVAL, t0 + 2 * per, e0 + 60, F_LIVE, 0, 1, result_of(ST_PFAIL, 0, 0, 0, 0));
    add_row(CMD_DONE, t0 + 3 * per, e0 - 100, 0, 0, 1, result_of(ST_COMMITTED, 0, 0, 0, 0));
    add_row(CMD_EVAL, NOW_MAX, e0 + 60, F_LIVE, 0, 1, result_of(ST_PFAIL, 0, 0, 0, 1));
    add_row(CMD_EVAL, 0, e0 + 60, F_LIVE, 0, 0, '0);

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

    random_phase(250, 60, EPOCH_WIDTH'(64'd1800000000));

    program_limits(8'd2, 32'd20, 32'd5, 32'd3, EPOCH_WIDTH'(64'd1000000000),
                   EPOCH_WIDTH'(64'd3000000000));
    calm = 1'b1;
    random_phase(250, 5, EPOCH_WIDTH'(64'd1500000000));
    drain_results();
    calm = 1'b0;

    program_limits(8'd1, 32'd1, 32'd1, 32'd0, '0, EPOCH_MAX);
    random_phase(250, 2, EPOCH_WIDTH'({$urandom, $urandom}));

    program_limits(8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, '0, EPOCH_MAX);
    // failure counter must hold at its ceiling
    for (int n = 0; n < 270; n++) begin
      r = make_req(CMD_FAIL, 64'(n), 0, 6'($urandom) & ~F_UNC, 0);
      send_request(r, 1'b0, '0);
    end
    for (int n = 0; n < 4; n++) begin
      r = make_req(CMD_EVAL, 64'd1000, e0, F_LIVE, 0);
      send_request(r, 1'b0, '0);
    end
    random_phase(200, 100, e0);

    program_limits(8'd4, 32'd100, 32'd10, 32'd5, EPOCH_WIDTH'(64'd3000000000),
                   EPOCH_WIDTH'(64'd1000000000));
    random_phase(200, 10, e0);

    program_limits(8'd0, 32'd0, 32'd0, 32'd0, '0, EPOCH_MAX);
    random_phase(200, 3, e0);

    lo = EPOCH_WIDTH'($urandom_range(1000000000, 2000000000));
    rnd_period = $urandom_range(1, 60);
    program_limits(8'($urandom_range(1, 8)), $urandom_range(5, 500), rnd_period,
                   $urandom_range(0, 40), lo, lo + EPOCH_WIDTH'($urandom_range(1000000, 2000000000)));
    random_phase(100, rnd_period, lo + EPOCH_WIDTH'($urandom_range(0, 100000)));

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("heartbeat_failsafe_scheduler_core regression: pass");
    else
      $display("heartbeat_failsafe_scheduler_core regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/hfs_pkg.sv
hdl/hfs_cfg.sv
hdl/hfs_engine.sv
hdl/heartbeat_failsafe_scheduler_core.sv
bench/heartbeat_failsafe_scheduler_core_tb.sv
